// ----- rtl/core/ridbc_pkg.sv -----
// ----------------------------------------------------------------------------
// ridbc_pkg
// Shared widths, operation codes and command type of the rule id compactor.
// ----------------------------------------------------------------------------
package ridbc_pkg;

   // request / result field widths
   localparam int FUNC_W  = 2;
   localparam int ID_W    = 16;
   localparam int MAXO_W  = 7;
   localparam int FOUND_W = 12;
   localparam int CFG_W   = 13;

   // register reset value
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   // parameter defaults
   localparam int MAX_RULES_DEF = 4096;
   localparam int MAX_EMIT_DEF  = 64;

   // bitmap geometry
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   // widths that cover the full MAX_RULES range (up to 65536)
   localparam int ADDR_MAX_W = ID_W - BIT_W;      // word address
   localparam int WCNT_W     = ADDR_MAX_W + 1;    // word count, up to 1024
   localparam int RULE_W     = ID_W + 1;          // rule count, up to 65536

   localparam int QUEUE_DEPTH = 4;

   // request operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

   // one queued command, front to back
   typedef struct packed {
      logic [FUNC_W-1:0]     op;
      logic [ADDR_MAX_W-1:0] addr;
      logic [BIT_W-1:0]      bit_sel;
      logic [MAXO_W-1:0]     limit;
      logic [WCNT_W-1:0]     nwords;
   } cmd_type;

   // back-end status seen by the front
   typedef struct packed {
      logic init_busy;
   } back_status_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
   } queue_status_type;

endpackage

// ----- rtl/core/ridbc_req_if.sv -----
// ----------------------------------------------------------------------------
// ridbc_req_if
// Request channel: operation, rule id and emit limit with valid/ready.
// ----------------------------------------------------------------------------
interface ridbc_req_if
   import ridbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   rule_id;
   logic [MAXO_W-1:0] max_out;

   modport source (output valid, output func, output rule_id, output max_out,
                   input ready);
   modport sink   (input valid, input func, input rule_id, input max_out,
                   output ready);
endinterface

// ----- rtl/core/ridbc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ridbc_rsp_if
// Result channel: found id, empty and last flags with valid/ready.
// ----------------------------------------------------------------------------
interface ridbc_rsp_if
   import ridbc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FOUND_W-1:0] found_id;
   logic               is_empty;
   logic               last;

   modport source (output valid, output found_id, output is_empty, output last,
                   input ready);
   modport sink   (input valid, input found_id, input is_empty, input last,
                   output ready);
endinterface

// ----- rtl/core/ridbc_front.sv -----
// ----------------------------------------------------------------------------
// ridbc_front
// Accepts requests, holds the rule count register, drops no-op requests
// and out-of-range sets and turns the rest into queued commands.
// ----------------------------------------------------------------------------
module ridbc_front
   import ridbc_pkg::*;
#(
   parameter int MAX_RULES = MAX_RULES_DEF,
   parameter int MAX_EMIT  = MAX_EMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   ridbc_req_if.sink        req,
   input  back_status_type  back_st,
   input  queue_status_type queue_st,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [CFG_W-1:0]  active_ff;
   logic [RULE_W-1:0] rules_eff;
   logic [RULE_W-1:0] rules_rnd;
   logic              in_range;
   logic              keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // clamp to MAX_RULES, then round up to whole words
   always_comb begin
      if (RULE_W'(active_ff) > RULE_W'(MAX_RULES)) begin
         rules_eff = RULE_W'(MAX_RULES);
      end else begin
         rules_eff = RULE_W'(active_ff);
      end
      rules_rnd = rules_eff + RULE_W'(WORD_BITS - 1);
      in_range  = RULE_W'(req.rule_id) < rules_eff;
   end

   always_comb begin
      keep = 1'b0;
      unique case (req.func)
         FUNC_SET:     keep = in_range;
         FUNC_COMPACT: keep = 1'b1;
         FUNC_CLEAR:   keep = 1'b1;
         default:      keep = 1'b0;   // unused code, no effect
      endcase
   end

   assign req.ready = !back_st.init_busy && !queue_st.full;
   assign push      = req.valid && req.ready && keep;

   always_comb begin
      push_cmd.op      = req.func;
      push_cmd.addr    = req.rule_id[ID_W-1:BIT_W];
      push_cmd.bit_sel = req.rule_id[BIT_W-1:0];
      push_cmd.nwords  = rules_rnd[RULE_W-1:BIT_W];
      if (req.max_out > MAXO_W'(MAX_EMIT)) begin
         push_cmd.limit = MAXO_W'(MAX_EMIT);
      end else begin
         push_cmd.limit = req.max_out;
      end
   end

endmodule

// ----- rtl/core/ridbc_queue.sv -----
// ----------------------------------------------------------------------------
// ridbc_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module ridbc_queue
   import ridbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   output queue_status_type queue_st,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output logic             empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign empty       = (count_ff == '0);
   assign queue_st.full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign do_push     = push && !queue_st.full;
   assign do_pop      = pop && !empty;
   assign pop_cmd     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (PTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (PTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- rtl/core/ridbc_back.sv -----
// ----------------------------------------------------------------------------
// ridbc_back
// Bitmap word memory and the sequencer that runs set, clear and compact,
// with the result output register.
// ----------------------------------------------------------------------------
module ridbc_back
   import ridbc_pkg::*;
#(
   parameter int MAX_RULES = MAX_RULES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            empty,
   input  cmd_type         pop_cmd,
   output logic            pop,
   output back_status_type back_st,
   ridbc_rsp_if.source     rsp
);

   localparam int WORDS = (MAX_RULES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETWR = 3'd1;
   localparam logic [2:0] ST_CLR   = 3'd2;
   localparam logic [2:0] ST_CLOAD = 3'd3;
   localparam logic [2:0] ST_CSCAN = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   // word memory
   logic [WORD_BITS-1:0] mem [WORDS];
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control
   logic [2:0]           state_ff,  state_in;
   logic                 init_ff,   init_in;
   logic [AW-1:0]        clr_ff,    clr_in;
   logic [AW-1:0]        addr_ff,   addr_in;
   logic [BIT_W-1:0]     bit_ff,    bit_in;
   logic [MAXO_W-1:0]    lim_ff,    lim_in;
   logic [MAXO_W-1:0]    cnt_ff,    cnt_in;
   logic [WCNT_W-1:0]    nw_ff,     nw_in;
   logic [WCNT_W-1:0]    wi_ff,     wi_in;
   logic [WORD_BITS-1:0] w_ff,      w_in;
   logic                 pend_v_ff, pend_v_in;
   logic [FOUND_W-1:0]   pend_ff,   pend_in;

   // output register
   logic               out_v_ff;
   logic [FOUND_W-1:0] out_id_ff;
   logic               out_empty_ff;
   logic               out_last_ff;
   logic               out_load;
   logic [FOUND_W-1:0] out_id_in;
   logic               out_empty_in;
   logic               out_last_in;
   logic               out_free;

   // lowest set bit of the current word
   logic [WORD_BITS-1:0] low_onehot;
   logic [BIT_W-1:0]     low_idx;

   always_comb begin
      low_onehot = w_ff & (~w_ff + WORD_BITS'(1));
      low_idx    = '0;
      for (int k = 0; k < BIT_W; k++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (((i >> k) & 1) == 1) begin
               low_idx[k] = low_idx[k] | low_onehot[i];
            end
         end
      end
   end

   assign out_free        = !out_v_ff || rsp.ready;
   assign back_st.init_busy = init_ff;

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      lim_in       = lim_ff;
      cnt_in       = cnt_ff;
      nw_in        = nw_ff;
      wi_in        = wi_ff;
      w_in         = w_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = rd_data_ff | (WORD_BITS'(1) << bit_ff);
      out_load     = 1'b0;
      out_id_in    = pend_ff;
      out_empty_in = 1'b0;
      out_last_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               case (pop_cmd.op)
                  FUNC_SET: begin
                     rd_en    = 1'b1;
                     rd_addr  = pop_cmd.addr[AW-1:0];
                     addr_in  = pop_cmd.addr[AW-1:0];
                     bit_in   = pop_cmd.bit_sel;
                     state_in = ST_SETWR;
                  end
                  FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  default: begin   // compact
                     lim_in    = pop_cmd.limit;
                     nw_in     = pop_cmd.nwords;
                     cnt_in    = '0;
                     pend_v_in = 1'b0;
                     if (pop_cmd.nwords == '0 || pop_cmd.limit == '0) begin
                        state_in = ST_FIN;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        addr_in  = '0;
                        wi_in    = WCNT_W'(1);
                        state_in = ST_CLOAD;
                     end
                  end
               endcase
            end
         end
         ST_SETWR: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == AW'(WORDS - 1)) begin
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_CLOAD: begin
            w_in     = rd_data_ff;
            state_in = ST_CSCAN;
         end
         ST_CSCAN: begin
            if (w_ff == '0 || cnt_ff == lim_ff) begin
               if (cnt_ff == lim_ff || wi_ff == nw_ff) begin
                  state_in = ST_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = wi_ff[AW-1:0];
                  addr_in  = wi_ff[AW-1:0];
                  wi_in    = wi_ff + WCNT_W'(1);
                  state_in = ST_CLOAD;
               end
            end else if (!pend_v_ff || out_free) begin
               // previous hit is known not to be last now
               out_load  = pend_v_ff;
               pend_v_in = 1'b1;
               pend_in   = FOUND_W'({addr_ff, low_idx});
               w_in      = w_ff & (w_ff - WORD_BITS'(1));
               cnt_in    = cnt_ff + MAXO_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_last_in  = 1'b1;
               out_empty_in = !pend_v_ff;
               out_id_in    = pend_v_ff ? pend_ff : '0;
               pend_v_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLR;
         init_ff   <= 1'b1;
         clr_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         init_ff   <= init_in;
         clr_ff    <= clr_in;
         pend_v_ff <= pend_v_in;
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      bit_ff  <= bit_in;
      lim_ff  <= lim_in;
      cnt_ff  <= cnt_in;
      nw_ff   <= nw_in;
      wi_ff   <= wi_in;
      w_ff    <= w_in;
      pend_ff <= pend_in;
      if (out_load) begin
         out_id_ff    <= out_id_in;
         out_empty_ff <= out_empty_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp.valid    = out_v_ff;
   assign rsp.found_id = out_id_ff;
   assign rsp.is_empty = out_empty_ff;
   assign rsp.last     = out_last_ff;

endmodule

// ----- rtl/core/rule_id_bitmap_compactor_unit.sv -----
// ----------------------------------------------------------------------------
// rule_id_bitmap_compactor_unit
// Rule id bitmap: set / clear / compact into an ascending id list.
// ----------------------------------------------------------------------------
// A request carries func (0 set, 1 compact, 2 clear, 3 no-op), rule_id and
// max_out. Set marks one id below the active rule count (held in the csr
// register, clamped to MAX_RULES); duplicates merge. Compact returns the
// marked ids in ascending order, at most max_out (clamped to MAX_EMIT),
// flagging the final one with last; a compact that finds nothing or has a
// zero limit returns one result with is_empty and last set. The front
// takes one request per cycle into a 4-entry command queue while the
// queue has room and no reset sweep runs; out-of-range sets and no-op
// requests are dropped there and never reach the back end. The back end
// owns the word memory, with one read and one write port. A set is a
// read-modify-write of one 64-bit word: the pop reads it and ST_SETWR
// writes it back, so a steady stream of in-range sets fills the queue.
// A clear takes the pop and then sweeps the memory one word a cycle. A
// compact pops and reads word 0, loads each scanned word in ST_CLOAD,
// reports its marked ids in ST_CSCAN and closes in ST_FIN, waiting while
// the result side stalls; a zero limit or zero rule count goes from the
// pop straight to ST_FIN. After reset the same sweep clears the bitmap,
// and req_ch.ready stays low until it is done. Results leave from an output
// register, so the back end keeps working while a result waits to be taken.
// ----------------------------------------------------------------------------
module rule_id_bitmap_compactor_unit
   import ridbc_pkg::*;
#(
   parameter int MAX_RULES = MAX_RULES_DEF,
   parameter int MAX_EMIT  = MAX_EMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // rule count register
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   // request and result channels
   ridbc_req_if.sink        req_ch,
   ridbc_rsp_if.source      rsp_ch
);

   back_status_type  back_st;
   queue_status_type queue_st;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;
   logic             q_empty;

   // front: register, filtering of out-of-range sets and no-ops
   ridbc_front #(
      .MAX_RULES (MAX_RULES),
      .MAX_EMIT  (MAX_EMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .back_st     (back_st),
      .queue_st    (queue_st),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoupling queue
   ridbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .queue_st (queue_st),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // back: word memory, sequencer, result register
   ridbc_back #(
      .MAX_RULES (MAX_RULES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (q_empty),
      .pop_cmd (pop_cmd),
      .pop     (pop),
      .back_st (back_st),
      .rsp     (rsp_ch)
   );

endmodule

// ----- rtl/core/ridbc_checker.sv -----
// ----------------------------------------------------------------------------
// ridbc_checker
// Port-level assertions on the compactor, bound to the top level.
// ----------------------------------------------------------------------------
module ridbc_checker
   import ridbc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FOUND_W-1:0] rsp_found_id,
   input logic               rsp_is_empty,
   input logic               rsp_last
);

   // bitmap clearing pass holds off requests right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during post-reset clear");

   // empty result is always a single closing one with id zero
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_last && (rsp_found_id == '0))
      else $error("empty result not last or id not zero");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // ids of one compact run only rise
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last && !rsp_is_empty ##1
      rsp_valid && !rsp_is_empty |-> rsp_found_id > $past(rsp_found_id))
      else $error("compact ids not ascending");

endmodule

bind rule_id_bitmap_compactor_unit ridbc_checker u_ridbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_found_id (rsp_ch.found_id),
   .rsp_is_empty (rsp_ch.is_empty),
   .rsp_last     (rsp_ch.last)
);

// ----- dv/rule_id_bitmap_compactor_unit_test.sv -----
// ----------------------------------------------------------------------------
// rule_id_bitmap_compactor_unit_test
// Self-checking bench for the rule id bitmap compactor. It keeps a shadow
// bitmap and rule count, works out the ids each compact owes, and checks
// every result in order. A directed table comes first, then random
// set/compact episodes under several rule counts, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module rule_id_bitmap_compactor_unit_test;
   import ridbc_pkg::*;

   localparam int MAP_WORDS      = (MAX_RULES_DEF + WORD_BITS - 1) / WORD_BITS;
   localparam int PHASES         = 7;
   localparam int PHASE_REQUESTS = 40;      // counted requests per phase
   localparam int SETTLE_CYCLES  = 400;     // covers queued clears and init sweep
   localparam int LONG_HOLD      = 600;     // result side held off once
   localparam int SHOWN_FAULTS   = 10;
   localparam int CYCLE_LIMIT    = 10000000;
   localparam int PROBE_ROWS     = 25;

   // one result of a compact
   typedef struct packed {
      logic [FOUND_W-1:0] found_id;
      logic               is_empty;
      logic               last;
   } rule_hit_t;

   // one directed request; typed rows carry their single result by hand
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ID_W-1:0]    rule_id;
      logic [MAXO_W-1:0]  max_out;
      logic               typed;
      logic [FOUND_W-1:0] want_id;
      logic               want_empty;
   } probe_row_t;

   logic clock;
   logic reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   ridbc_req_if req_ch ();
   ridbc_rsp_if rsp_ch ();

   rule_id_bitmap_compactor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow state of the block
   logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
   logic [CFG_W-1:0]     rule_count;
   rule_hit_t            owed_ids [$];     // results the block still owes

   int  fault_count;
   int  requests_sent;                     // set/compact/clear requests accepted
   int  cycle_count;
   bit  sender_steady;                     // episode with no sender gaps

   // result side pacing
   bit  ready_on;
   int  ready_run;
   int  hold_left;
   bit  hold_done;
   int  results_taken;
   rule_hit_t want;

   // Directed requests, run under the reset rule count (4096).
   probe_row_t probe_table [PROBE_ROWS] = '{
      '{FUNC_COMPACT, 16'h0000, 7'd64,  1'b1, 12'd0,    1'b1},  // empty after reset
      '{FUNC_COMPACT, 16'hFFFF, 7'd0,   1'b1, 12'd0,    1'b1},  // zero limit
      '{FUNC_SET,     16'd0,    7'h7F,  1'b0, 12'd0,    1'b0},  // lowest id
      '{FUNC_SET,     16'd4095, 7'd0,   1'b0, 12'd0,    1'b0},  // highest id
      '{FUNC_SET,     16'd4096, 7'd0,   1'b0, 12'd0,    1'b0},  // first ignored id
      '{FUNC_SET,     16'hFFFF, 7'h7F,  1'b0, 12'd0,    1'b0},  // widest id, ignored
      '{FUNC_SET,     16'd0,    7'd0,   1'b0, 12'd0,    1'b0},  // duplicate merges
      '{FUNC_UNUSED,  16'd100,  7'h7F,  1'b0, 12'd0,    1'b0},  // no-op, marks nothing
      '{FUNC_COMPACT, 16'd0,    7'd0,   1'b1, 12'd0,    1'b1},  // zero limit with marks
      '{FUNC_COMPACT, 16'd0,    7'd1,   1'b1, 12'd0,    1'b0},  // limit of one
      '{FUNC_SET,     16'd63,   7'd0,   1'b0, 12'd0,    1'b0},  // word edge
      '{FUNC_SET,     16'd64,   7'd0,   1'b0, 12'd0,    1'b0},  // next word
      '{FUNC_COMPACT, 16'd0,    7'h7F,  1'b0, 12'd0,    1'b0},  // oversized limit
      '{FUNC_COMPACT, 16'd0,    7'd64,  1'b0, 12'd0,    1'b0},
      '{FUNC_COMPACT, 16'd0,    7'd3,   1'b0, 12'd0,    1'b0},  // truncated run
      '{FUNC_SET,     16'h5555, 7'h2A,  1'b0, 12'd0,    1'b0},  // ignored
      '{FUNC_SET,     16'h0AAA, 7'h55,  1'b0, 12'd0,    1'b0},
      '{FUNC_COMPACT, 16'hAAAA, 7'h55,  1'b0, 12'd0,    1'b0},
      '{FUNC_CLEAR,   16'hFFFF, 7'h7F,  1'b0, 12'd0,    1'b0},
      '{FUNC_COMPACT, 16'd0,    7'd64,  1'b1, 12'd0,    1'b1},  // empty after clear
      '{FUNC_SET,     16'd4095, 7'd0,   1'b0, 12'd0,    1'b0},
      '{FUNC_COMPACT, 16'd0,    7'h7F,  1'b1, 12'd4095, 1'b0},  // single top id
      '{FUNC_CLEAR,   16'd0,    7'd0,   1'b0, 12'd0,    1'b0},
      '{FUNC_SET,     16'd1,    7'd0,   1'b0, 12'd0,    1'b0},
      '{FUNC_COMPACT, 16'd0,    7'h2A,  1'b0, 12'd0,    1'b0}
   };

   // rule counts per phase: extremes, clamp, zero, small, then one random
   logic [CFG_W-1:0] rule_settings [PHASES] = '{
      13'd4096, 13'd8191, 13'd64, 13'd1, 13'd0, 13'd100, 13'd4096
   };

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // rule count as the block uses it
   function automatic int effective_rules();
      return (rule_count > MAX_RULES_DEF) ? MAX_RULES_DEF : int'(rule_count);
   endfunction

   // Applies one accepted request to the shadow state; compact appends the
   // ids it owes, in ascending order, to owed_ids.
   function automatic void mirror_request(input logic [FUNC_W-1:0] func,
                                          input logic [ID_W-1:0]   id,
                                          input logic [MAXO_W-1:0] limit);
      int        rules;
      int        words;
      int        cap;
      int        count;
      int        wi;
      int        b;
      rule_hit_t hit;
      rules = effective_rules();
      case (func)
         FUNC_SET: begin
            if (int'(id) < rules)
               shadow_map[id / WORD_BITS][id % WORD_BITS] = 1'b1;
         end
         FUNC_CLEAR: begin
            for (wi = 0; wi < MAP_WORDS; wi++)
               shadow_map[wi] = '0;
         end
         FUNC_COMPACT: begin
            words = (rules + WORD_BITS - 1) / WORD_BITS;
            cap   = (int'(limit) > MAX_EMIT_DEF) ? MAX_EMIT_DEF : int'(limit);
            count = 0;
            // stale marks above the current count still show within scanned words
            for (wi = 0; wi < words && count < cap; wi++) begin
               for (b = 0; b < WORD_BITS && count < cap; b++) begin
                  if (shadow_map[wi][b]) begin
                     hit.found_id = FOUND_W'(wi * WORD_BITS + b);
                     hit.is_empty = 1'b0;
                     hit.last     = 1'b0;
                     owed_ids.push_back(hit);
                     count++;
                  end
               end
            end
            if (count == 0) begin
               hit.found_id = '0;
               hit.is_empty = 1'b1;
               hit.last     = 1'b1;
               owed_ids.push_back(hit);
            end else begin
               owed_ids[owed_ids.size() - 1].last = 1'b1;
            end
         end
         default: ;   // unused code: nothing happens
      endcase
   endfunction

   function automatic void note_fault(input string what, input int want_v, input int got_v);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("mismatch %0d: %s expected %0d got %0d", fault_count, what, want_v, got_v);
   endfunction

   // Sender gap: mostly none, some short, a few long.
   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Mostly ids in range, some at the boundary, some packed into word 0,
   // some anywhere in the 16-bit field.
   function automatic logic [ID_W-1:0] pick_rule_id();
      int rules;
      int roll;
      rules = effective_rules();
      roll  = $urandom_range(0, 99);
      if (rules == 0 || roll >= 85)
         return ID_W'($urandom_range(0, 65535));
      if (roll < 60)
         return ID_W'($urandom_range(0, rules - 1));
      if (roll < 75)
         return ID_W'(rules - 1 + $urandom_range(0, 2));
      return ID_W'($urandom_range(0, ((rules < WORD_BITS) ? rules : WORD_BITS) - 1));
   endfunction

   function automatic logic [MAXO_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return '0;
      if (roll < 70)
         return MAXO_W'($urandom_range(1, 64));
      if (roll < 85)
         return MAXO_W'($urandom_range(65, 127));
      return MAXO_W'($urandom_range(0, 127));
   endfunction

   // Drives one request and waits for it to be taken. valid stays high
   // when no gap follows, so back-to-back requests never toggle it.
   task automatic offer_request(input logic [FUNC_W-1:0] func,
                                input logic [ID_W-1:0]   id,
                                input logic [MAXO_W-1:0] limit,
                                input bit                mirror);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.func    <= func;
      req_ch.rule_id <= id;
      req_ch.max_out <= limit;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (mirror)
         mirror_request(func, id, limit);
      if (func != FUNC_UNUSED)
         requests_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         // junk on the payload while idle
         req_ch.valid   <= 1'b0;
         req_ch.func    <= FUNC_W'($urandom);
         req_ch.rule_id <= ID_W'($urandom);
         req_ch.max_out <= MAXO_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every owed result has come back.
   task automatic wait_owed_empty();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (owed_ids.size() != 0);
   endtask

   task automatic write_rule_count(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rule_count   = value;
   endtask

   // One episode: optional clear, a run of sets with some noise, a compact.
   task automatic run_episode(input bit may_clear);
      int n_marks;
      int k;
      sender_steady = ($urandom_range(0, 3) == 0);
      if (may_clear && $urandom_range(0, 3) == 0)
         offer_request(FUNC_CLEAR, ID_W'($urandom), MAXO_W'($urandom), 1'b1);
      n_marks = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
      for (k = 0; k < n_marks; k++) begin
         if ($urandom_range(0, 9) == 0)
            offer_request(FUNC_UNUSED, ID_W'($urandom), MAXO_W'($urandom), 1'b1);
         if ($urandom_range(0, 49) == 0)   // broken episode: clear mid-run
            offer_request(FUNC_CLEAR, ID_W'($urandom), MAXO_W'($urandom), 1'b1);
         offer_request(FUNC_SET, pick_rule_id(), MAXO_W'($urandom), 1'b1);
      end
      offer_request(FUNC_COMPACT, ID_W'($urandom), pick_limit(), 1'b1);
      // now and then the sender waits for the whole run to come back,
      // but never while the result side is held off
      if (hold_left == 0 && $urandom_range(0, 9) == 0)
         wait_owed_empty();
   endtask

   // Result side: check each taken result, then pick the next ready level.
   // One long hold-off is started in the middle of a compact run so the
   // back end stalls and the request queue fills up behind it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            if (owed_ids.size() == 0) begin
               note_fault("unexpected result, found_id", -1, int'(rsp_ch.found_id));
            end else begin
               want = owed_ids.pop_front();
               if (rsp_ch.found_id !== want.found_id)
                  note_fault("found_id", int'(want.found_id), int'(rsp_ch.found_id));
               if (rsp_ch.is_empty !== want.is_empty)
                  note_fault("is_empty", int'(want.is_empty), int'(rsp_ch.is_empty));
               if (rsp_ch.last !== want.last)
                  note_fault("last", int'(want.last), int'(rsp_ch.last));
            end
            if (!hold_done && results_taken >= 20 && !rsp_ch.last) begin
               hold_left = LONG_HOLD;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (ready_run == 0) begin
               ready_on = !ready_on;
               if (ready_on)
                  ready_run = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 20);
               else
                  ready_run = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
            end
            ready_run--;
            rsp_ch.ready <= ready_on;
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int               p;
      int               r;
      int               phase_end;
      logic [CFG_W-1:0] setting;

      // every input known from time 0
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = CFG_RESET;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_SET;
      req_ch.rule_id = '0;
      req_ch.max_out = '0;
      rsp_ch.ready   = 1'b0;
      rule_count     = CFG_RESET;
      for (r = 0; r < MAP_WORDS; r++)
         shadow_map[r] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         // block idle: nothing owed, queued clears and the init sweep done
         wait_owed_empty();
         repeat (SETTLE_CYCLES) @(posedge clock);
         setting = (p == PHASES - 1) ? CFG_W'($urandom_range(2, 4095)) : rule_settings[p];
         write_rule_count(setting);
         phase_end = requests_sent + PHASE_REQUESTS;

         if (p == 0) begin
            for (r = 0; r < PROBE_ROWS; r++) begin
               if (probe_table[r].typed)
                  owed_ids.push_back('{found_id: probe_table[r].want_id,
                                       is_empty: probe_table[r].want_empty,
                                       last:     1'b1});
               offer_request(probe_table[r].func, probe_table[r].rule_id,
                             probe_table[r].max_out, !probe_table[r].typed);
            end
         end

         // first episode of a phase keeps earlier marks to exercise stale bits
         run_episode(1'b0);
         // keep offering while the result side is held off, so the queue fills
         while (requests_sent < phase_end || hold_left > 0)
            run_episode(1'b1);
      end

      wait_owed_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_ids.size() != 0)
         note_fault("results never returned", 0, owed_ids.size());

      if (fault_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
